// File: design/crsb_pkg.sv
// Shared constants, codes, types and the CRC32 lookup table for the row staging buffer.
`timescale 1ns / 1ps
`default_nettype none

package crsb_pkg;

    // Staging store geometry.
    localparam int STAGE_BYTES = 24576;
    localparam int ADDR_W      = $clog2(STAGE_BYTES);
    localparam int LEN_W       = 15;

    // CRC32, reflected form.
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_SEED = 32'hFFFFFFFF;
    localparam logic [7:0]  NEWLINE  = 8'h0A;

    // Request codes carried by req_type.
    typedef enum logic [2:0] {
        REQ_START  = 3'd0,
        REQ_HEADER = 3'd1,
        REQ_ROW    = 3'd2,
        REQ_READ   = 3'd3,
        REQ_FLUSH  = 3'd4,
        REQ_FINISH = 3'd5
    } req_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_DROPPED  = 2'd1,
        STAT_WR_FAIL  = 2'd2,
        STAT_INACTIVE = 2'd3
    } status_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_FOLD,
        ST_MOVE,
        ST_FLUSH_END
    } state_t;

    // One cycle of requests to the staging memory.
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } mem_req_t;

    typedef logic [31:0] crc_table_t [256];

    // Builds the byte-wise lookup table at elaboration.
    function automatic crc_table_t crc_build_table();
        crc_table_t  tbl;
        logic [31:0] c;
        for (int i = 0; i < 256; i++)
        begin
            c = 32'(i);
            for (int k = 0; k < 8; k++)
            begin
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            end
            tbl[i] = c;
        end
        return tbl;
    endfunction

    localparam crc_table_t CRC_TABLE = crc_build_table();

endpackage

`default_nettype wire

// File: design/crc_checked_row_staging_buffer.sv
// Top level: request sequencer, counters and result register of the row staging buffer.
//
//   channel  | handshake           | payload
//   ---------+---------------------+--------------------------------------------------
//   in       | in_valid / in_stall | req_type data_byte row_end write_ok sync_ok
//            |                     | read_index
//   out      | out_valid/out_stall | status read_data checksum committed_bytes
//            |                     | committed_rows overflow_total failure_total
//            |                     | fill_level fill_peak flushed_count
//
// Start, header, row, finish and ignored beats are handled in the idle state; a read
// goes through the staging memory's registered read port. A flush with a good ack
// walks the staged bytes through that single read port, one byte a cycle, and then
// moves a pending row to the front of the store.
// Reset is asynchronous and active low; the byte store itself is not cleared.
// A new beat is taken only while the sequencer is idle and the result register is
// empty or being drained in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module crc_checked_row_staging_buffer
    import crsb_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,

    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [2:0]        req_type,
    input  wire logic [7:0]        data_byte,
    input  wire logic              row_end,
    input  wire logic              write_ok,
    input  wire logic              sync_ok,
    input  wire logic [14:0]       read_index,

    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [1:0]             status,
    output logic [7:0]             read_data,
    output logic [31:0]            checksum,
    output logic [31:0]            committed_bytes,
    output logic [31:0]            committed_rows,
    output logic [31:0]            overflow_total,
    output logic [31:0]            failure_total,
    output logic [14:0]            fill_level,
    output logic [14:0]            fill_peak,
    output logic [14:0]            flushed_count
);

    // Control and architectural state.
    state_t           state_reg, state_next;
    logic             out_valid_reg, out_valid_next;
    logic             running_reg, running_next;
    logic [LEN_W-1:0] stage_len_reg, stage_len_next;
    logic [LEN_W-1:0] pending_len_reg, pending_len_next;
    logic             row_ovf_reg, row_ovf_next;
    logic [31:0]      crc_reg, crc_next;
    logic [31:0]      byte_total_reg, byte_total_next;
    logic [31:0]      row_total_reg, row_total_next;
    logic [31:0]      overflow_cnt_reg, overflow_cnt_next;
    logic [31:0]      failure_cnt_reg, failure_cnt_next;
    logic [LEN_W-1:0] peak_reg, peak_next;
    logic             ewnl_reg, ewnl_next;
    logic [LEN_W-1:0] cnt_reg, cnt_next;
    logic             vld_reg, vld_next;
    logic [LEN_W-1:0] dst_reg, dst_next;
    logic             sync_ok_reg, sync_ok_next;
    logic             in_range_reg, in_range_next;

    // Result payload.
    status_t          status_reg, status_next;
    logic [7:0]       read_data_reg, read_data_next;
    logic [LEN_W-1:0] flushed_reg, flushed_next;

    // Datapath signals.
    mem_req_t         mem_req;
    logic [7:0]       mem_q;
    logic [7:0]       fold_byte;
    logic [31:0]      fold_crc;
    logic             accept;
    logic [LEN_W:0]   row_pos;
    logic [LEN_W-1:0] move_src;
    logic [LEN_W-1:0] row_commit;

    crsb_stage_mem u_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (mem_q)
    );

    crsb_crc_fold u_crc (
        .crc_in  (crc_reg),
        .byte_in (fold_byte),
        .crc_out (fold_crc)
    );

    // Input side handshake.
    assign in_stall = !((state_reg == ST_IDLE) && (!out_valid_reg || !out_stall));
    assign accept   = in_valid && !in_stall;

    // A committing row byte is always appended, so the row ends one past its position.
    assign row_pos    = {1'b0, stage_len_reg} + {1'b0, pending_len_reg};
    assign move_src   = stage_len_reg + cnt_reg;
    assign row_commit = row_pos[LEN_W-1:0] + 1'b1;

    // Next-state logic for the sequencer, counters and result register.
    always_comb
    begin
        state_next        = state_reg;
        out_valid_next    = out_valid_reg && out_stall;
        running_next      = running_reg;
        stage_len_next    = stage_len_reg;
        pending_len_next  = pending_len_reg;
        row_ovf_next      = row_ovf_reg;
        crc_next          = crc_reg;
        byte_total_next   = byte_total_reg;
        row_total_next    = row_total_reg;
        overflow_cnt_next = overflow_cnt_reg;
        failure_cnt_next  = failure_cnt_reg;
        peak_next         = peak_reg;
        ewnl_next         = ewnl_reg;
        cnt_next          = cnt_reg;
        vld_next          = vld_reg;
        dst_next          = dst_reg;
        sync_ok_next      = sync_ok_reg;
        in_range_next     = in_range_reg;
        status_next       = status_reg;
        read_data_next    = read_data_reg;
        flushed_next      = flushed_reg;
        mem_req           = '0;
        fold_byte         = data_byte;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    status_next    = STAT_OK;
                    read_data_next = 8'd0;
                    flushed_next   = '0;
                    out_valid_next = 1'b1;
                    if (req_t'(req_type) == REQ_START)
                    begin
                        stage_len_next    = '0;
                        pending_len_next  = '0;
                        row_ovf_next      = 1'b0;
                        crc_next          = CRC_SEED;
                        byte_total_next   = '0;
                        row_total_next    = '0;
                        overflow_cnt_next = '0;
                        failure_cnt_next  = '0;
                        peak_next         = '0;
                        ewnl_next         = 1'b1;
                        running_next      = 1'b1;
                    end
                    else if (req_t'(req_type) == REQ_READ)
                    begin
                        in_range_next   = ({1'b0, read_index} < (LEN_W+1)'(STAGE_BYTES));
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = read_index[ADDR_W-1:0];
                        out_valid_next  = 1'b0;
                        state_next      = ST_READ;
                    end
                    else if (!running_reg && (req_t'(req_type) == REQ_HEADER
                             || req_t'(req_type) == REQ_ROW
                             || req_t'(req_type) == REQ_FLUSH
                             || req_t'(req_type) == REQ_FINISH))
                    begin
                        status_next = STAT_INACTIVE;
                    end
                    else
                    begin
                        unique case (req_t'(req_type))
                            REQ_HEADER:
                            begin
                                crc_next        = fold_crc;
                                byte_total_next = byte_total_reg + 32'd1;
                                ewnl_next       = (data_byte == NEWLINE);
                            end
                            REQ_ROW:
                            begin
                                // Append tentatively, or mark the row as dropped.
                                if (!row_ovf_reg)
                                begin
                                    if (row_pos < (LEN_W+1)'(STAGE_BYTES))
                                    begin
                                        mem_req.wr_en    = 1'b1;
                                        mem_req.wr_addr  = row_pos[ADDR_W-1:0];
                                        mem_req.wr_data  = data_byte;
                                        pending_len_next = pending_len_reg + 1'b1;
                                    end
                                    else
                                    begin
                                        row_ovf_next     = 1'b1;
                                        pending_len_next = '0;
                                    end
                                end
                                // The last byte of a row commits or counts it.
                                if (row_end)
                                begin
                                    if (row_ovf_next)
                                    begin
                                        overflow_cnt_next = overflow_cnt_reg + 32'd1;
                                        status_next       = STAT_DROPPED;
                                    end
                                    else
                                    begin
                                        stage_len_next = row_commit;
                                        if (row_commit > peak_reg)
                                        begin
                                            peak_next = row_commit;
                                        end
                                    end
                                    pending_len_next = '0;
                                    row_ovf_next     = 1'b0;
                                end
                            end
                            REQ_FLUSH:
                            begin
                                if (stage_len_reg != '0)
                                begin
                                    if (!write_ok)
                                    begin
                                        failure_cnt_next = failure_cnt_reg + 32'd1;
                                        status_next      = STAT_WR_FAIL;
                                    end
                                    else
                                    begin
                                        sync_ok_next   = sync_ok;
                                        cnt_next       = '0;
                                        vld_next       = 1'b0;
                                        out_valid_next = 1'b0;
                                        state_next     = ST_FOLD;
                                    end
                                end
                            end
                            REQ_FINISH:
                            begin
                                fold_byte = NEWLINE;
                                if (!ewnl_reg)
                                begin
                                    crc_next        = fold_crc;
                                    byte_total_next = byte_total_reg + 32'd1;
                                    row_total_next  = row_total_reg + 32'd1;
                                    ewnl_next       = 1'b1;
                                end
                                pending_len_next = '0;
                                row_ovf_next     = 1'b0;
                                running_next     = 1'b0;
                            end
                            default:
                            begin
                                // Unknown codes leave the state alone.
                            end
                        endcase
                    end
                end
            end

            ST_READ:
            begin
                read_data_next = in_range_reg ? mem_q : 8'd0;
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end

            ST_FOLD:
            begin
                // Issue one read a cycle and fold the byte returned in the next cycle.
                vld_next = 1'b0;
                if (cnt_reg < stage_len_reg)
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = cnt_reg[ADDR_W-1:0];
                    cnt_next        = cnt_reg + 1'b1;
                    vld_next        = 1'b1;
                end
                fold_byte = mem_q;
                if (vld_reg)
                begin
                    crc_next  = fold_crc;
                    ewnl_next = (mem_q == NEWLINE);
                    if (mem_q == NEWLINE)
                    begin
                        row_total_next = row_total_reg + 32'd1;
                    end
                end
                if ((cnt_reg == stage_len_reg) && !vld_reg)
                begin
                    cnt_next   = '0;
                    state_next = (pending_len_reg != '0) ? ST_MOVE : ST_FLUSH_END;
                end
            end

            ST_MOVE:
            begin
                // Copy the pending row down to the front of the store.
                vld_next = 1'b0;
                if (cnt_reg < pending_len_reg)
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = move_src[ADDR_W-1:0];
                    dst_next        = cnt_reg;
                    cnt_next        = cnt_reg + 1'b1;
                    vld_next        = 1'b1;
                end
                if (vld_reg)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = dst_reg[ADDR_W-1:0];
                    mem_req.wr_data = mem_q;
                end
                if ((cnt_reg == pending_len_reg) && !vld_reg)
                begin
                    state_next = ST_FLUSH_END;
                end
            end

            ST_FLUSH_END:
            begin
                byte_total_next = byte_total_reg + {{(32-LEN_W){1'b0}}, stage_len_reg};
                if (!sync_ok_reg)
                begin
                    failure_cnt_next = failure_cnt_reg + 32'd1;
                end
                status_next    = STAT_OK;
                read_data_next = 8'd0;
                flushed_next   = stage_len_reg;
                stage_len_next = '0;
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            out_valid_reg    <= 1'b0;
            running_reg      <= 1'b0;
            stage_len_reg    <= '0;
            pending_len_reg  <= '0;
            row_ovf_reg      <= 1'b0;
            crc_reg          <= CRC_SEED;
            byte_total_reg   <= '0;
            row_total_reg    <= '0;
            overflow_cnt_reg <= '0;
            failure_cnt_reg  <= '0;
            peak_reg         <= '0;
            ewnl_reg         <= 1'b1;
            cnt_reg          <= '0;
            vld_reg          <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            out_valid_reg    <= out_valid_next;
            running_reg      <= running_next;
            stage_len_reg    <= stage_len_next;
            pending_len_reg  <= pending_len_next;
            row_ovf_reg      <= row_ovf_next;
            crc_reg          <= crc_next;
            byte_total_reg   <= byte_total_next;
            row_total_reg    <= row_total_next;
            overflow_cnt_reg <= overflow_cnt_next;
            failure_cnt_reg  <= failure_cnt_next;
            peak_reg         <= peak_next;
            ewnl_reg         <= ewnl_next;
            cnt_reg          <= cnt_next;
            vld_reg          <= vld_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        dst_reg       <= dst_next;
        sync_ok_reg   <= sync_ok_next;
        in_range_reg  <= in_range_next;
        status_reg    <= status_next;
        read_data_reg <= read_data_next;
        flushed_reg   <= flushed_next;
    end

    // Result fields; the counters are frozen while a result waits.
    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign read_data       = read_data_reg;
    assign checksum        = ~crc_reg;
    assign committed_bytes = byte_total_reg;
    assign committed_rows  = row_total_reg;
    assign overflow_total  = overflow_cnt_reg;
    assign failure_total   = failure_cnt_reg;
    assign fill_level      = stage_len_reg;
    assign fill_peak       = peak_reg;
    assign flushed_count   = flushed_reg;

endmodule

`default_nettype wire

// File: design/crsb_stage_mem.sv
// Staging byte store: one write port and one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module crsb_stage_mem
    import crsb_pkg::*;
(
    input  wire logic     clk,
    input  wire mem_req_t req,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [STAGE_BYTES];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // Read port; the read data is registered.
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: design/crsb_crc_fold.sv
// Folds one byte into the running CRC32 through the lookup table.
`timescale 1ns / 1ps
`default_nettype none

module crsb_crc_fold
    import crsb_pkg::*;
(
    input  wire logic [31:0] crc_in,
    input  wire logic [7:0]  byte_in,
    output logic [31:0]      crc_out
);

    logic [7:0] idx;

    // Table-driven byte step of the reflected CRC.
    assign idx     = crc_in[7:0] ^ byte_in;
    assign crc_out = (crc_in >> 8) ^ CRC_TABLE[idx];

endmodule

`default_nettype wire
